// ===== sv/pls_pkg.sv =====
package pls_pkg;

  typedef enum logic [2:0] {
    MODE_ADD_FRONT  = 3'd0,
    MODE_ADD_BACK   = 3'd1,
    MODE_ADD_AT     = 3'd2,
    MODE_DROP_FRONT = 3'd3,
    MODE_DROP_BACK  = 3'd4,
    MODE_DROP_AT    = 3'd5,
    MODE_DUMP       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } dp_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] entry;
    logic [4:0]         entries_held;
    logic               last;
  } out_beat_t;

endpackage

// ===== sv/pls_datapath.sv =====
module pls_datapath #(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pls_pkg::dp_op_t    op,
  input  logic [CW-1:0]      pos,
  input  logic signed [31:0] value,
  output logic signed [31:0] head,
  output logic [CW-1:0]      count
);

  logic signed [31:0] cell_r   [CAPACITY];
  logic signed [31:0] cell_nxt [CAPACITY];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      tail_idx;

  assign tail_idx = count_r - CW'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] up_val;
    logic signed [31:0] dn_val;

    if (i == 0) begin : g_first
      assign dn_val = value;
    end else begin : g_mid_dn
      assign dn_val = cell_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign up_val = cell_r[i];
    end else begin : g_mid_up
      assign up_val = cell_r[i+1];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      case (op)
        pls_pkg::OP_INSERT: begin
          if (CW'(i) > pos) begin
            cell_nxt[i] = dn_val;
          end else if (CW'(i) == pos) begin
            cell_nxt[i] = value;
          end
        end
        pls_pkg::OP_REMOVE: begin
          if (CW'(i) >= pos) begin
            cell_nxt[i] = up_val;
          end
        end
        pls_pkg::OP_ROTATE: begin
          if (CW'(i) == tail_idx) begin
            cell_nxt[i] = cell_r[0];
          end else if (CW'(i) < tail_idx) begin
            cell_nxt[i] = up_val;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (op)
      pls_pkg::OP_INSERT: count_nxt = count_r + CW'(1);
      pls_pkg::OP_REMOVE: count_nxt = count_r - CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cell_r[0];
  assign count = count_r;

endmodule

// ===== sv/pls_ctrl.sv =====
module pls_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pls_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pls_pkg::out_beat_t out_data,
  output pls_pkg::dp_op_t    dp_op,
  output logic [CW-1:0]      dp_pos,
  input  logic signed [31:0] head,
  input  logic [CW-1:0]      count
);

  localparam int CMPW = (CW > 8) ? CW : 8;

  pls_pkg::state_t    state_r;
  pls_pkg::state_t    state_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      idx_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  pls_pkg::out_beat_t out_r;
  pls_pkg::out_beat_t beat;

  logic               slot_free;
  logic               acc;
  logic               empty;
  logic               full;
  logic               dump_last;
  logic [CMPW-1:0]    pos_ext;
  logic [CMPW-1:0]    cnt_ext;
  logic               emit;
  pls_pkg::status_t   st;
  logic [CW-1:0]      held;
  logic signed [31:0] beat_entry;
  logic               beat_last;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pls_pkg::S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign empty     = (count == '0);
  assign full      = (count == CW'(CAPACITY));
  assign dump_last = (idx_r == count - CW'(1));
  assign pos_ext   = CMPW'(in_data.position);
  assign cnt_ext   = CMPW'(count);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pls_pkg::S_IDLE: begin
        if (acc && in_data.mode == pls_pkg::MODE_DUMP && !empty) begin
          state_nxt = pls_pkg::S_DUMP;
        end
      end
      pls_pkg::S_DUMP: begin
        if (slot_free && dump_last) begin
          state_nxt = pls_pkg::S_IDLE;
        end
      end
      default: state_nxt = pls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dp_op      = pls_pkg::OP_NONE;
    dp_pos     = '0;
    emit       = 1'b0;
    st         = pls_pkg::ST_OK;
    held       = count;
    beat_entry = '0;
    beat_last  = 1'b1;
    idx_nxt    = idx_r;
    unique case (state_r)
      pls_pkg::S_IDLE: begin
        idx_nxt = '0;
        if (acc) begin
          unique case (in_data.mode) inside
            pls_pkg::MODE_ADD_FRONT, pls_pkg::MODE_ADD_BACK, pls_pkg::MODE_ADD_AT: begin
              emit = 1'b1;
              if (in_data.mode == pls_pkg::MODE_ADD_AT && pos_ext > cnt_ext) begin
                st = pls_pkg::ST_BADPOS;
              end else if (full) begin
                st = pls_pkg::ST_FULL;
              end else begin
                dp_op = pls_pkg::OP_INSERT;
                held  = count + CW'(1);
                if (in_data.mode == pls_pkg::MODE_ADD_BACK) begin
                  dp_pos = count;
                end else if (in_data.mode == pls_pkg::MODE_ADD_AT) begin
                  dp_pos = CW'(in_data.position);
                end
              end
            end
            pls_pkg::MODE_DROP_FRONT, pls_pkg::MODE_DROP_BACK, pls_pkg::MODE_DROP_AT: begin
              emit = 1'b1;
              if (empty) begin
                st = pls_pkg::ST_EMPTY;
              end else if (in_data.mode == pls_pkg::MODE_DROP_AT && pos_ext >= cnt_ext) begin
                st = pls_pkg::ST_BADPOS;
              end else begin
                dp_op = pls_pkg::OP_REMOVE;
                held  = count - CW'(1);
                if (in_data.mode == pls_pkg::MODE_DROP_BACK) begin
                  dp_pos = count - CW'(1);
                end else if (in_data.mode == pls_pkg::MODE_DROP_AT) begin
                  dp_pos = CW'(in_data.position);
                end
              end
            end
            pls_pkg::MODE_DUMP: begin
              if (empty) begin
                emit = 1'b1;
                st   = pls_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      pls_pkg::S_DUMP: begin
        if (slot_free) begin
          emit       = 1'b1;
          dp_op      = pls_pkg::OP_ROTATE;
          beat_entry = head;
          beat_last  = dump_last;
          idx_nxt    = idx_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    beat.status       = st;
    beat.entry        = beat_entry;
    beat.entries_held = 5'(held);
    beat.last         = beat_last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= beat;
    end
    if (!rst_n) begin
      state_r     <= pls_pkg::S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pls_pkg::S_DUMP |-> idx_r < count)
    else $error("dump index past fill count");

  a_dump_enter: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.mode == pls_pkg::MODE_DUMP && !empty |=> state_r == pls_pkg::S_DUMP)
    else $error("dump of non-empty list did not start");

  a_status_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != pls_pkg::ST_OK |-> out_r.entry == '0 && out_r.last)
    else $error("status beat carries entry data");

  a_dump_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pls_pkg::S_DUMP |-> dp_op == pls_pkg::OP_NONE || dp_op == pls_pkg::OP_ROTATE)
    else $error("list modified during dump");
`endif

endmodule

// ===== sv/positional_list_store.sv =====
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel in_valid/in_ready/in_data carries one command beat: mode,
// value and position. Output channel out_valid/out_ready/out_data returns
// result beats: status, entry, entries_held and last.
// Insert and remove commands give one status beat, registered, visible the
// cycle after the command is accepted. The list is a row of shift cells, so
// each insert or remove is done in the cycle it is accepted: one command per
// cycle while the receiver keeps up. Mode 7 is taken and gives no beat.
// A dump gives fill_count beats in entry order, one per cycle while the
// receiver keeps up, last set on the final one; the cells rotate once per
// beat and are back in order at the end. A dump of an empty list gives one
// empty status beat. A dump holds in_ready low until it emits its last beat.
// A new command is taken while the output register is empty or being drained
// that cycle; a stalled receiver holds the beat in place and blocks input.
// Reset (rst_n low, synchronous) empties the list and drops any pending beat.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pls_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pls_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  pls_pkg::dp_op_t    dp_op;
  logic [CW-1:0]      dp_pos;
  logic signed [31:0] head;
  logic [CW-1:0]      count;

  pls_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .dp_op     (dp_op),
    .dp_pos    (dp_pos),
    .head      (head),
    .count     (count)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (dp_op),
    .pos   (dp_pos),
    .value (in_data.value),
    .head  (head),
    .count (count)
  );

endmodule

// ===== sim/tb_positional_list_store.sv =====
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;
  localparam pls_pkg::mode_t MODE_RESERVED = pls_pkg::mode_t'(3'd7);
  localparam int RANDOM_ITEMS = 270;

  class list_mirror;
    logic signed [31:0] cells[CAPACITY];
    int unsigned        held;
    pls_pkg::out_beat_t due_beats[$];
    int                 mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void push_status(pls_pkg::status_t s);
      pls_pkg::out_beat_t b;
      b.status       = s;
      b.entry        = '0;
      b.entries_held = 5'(held);
      b.last         = 1'b1;
      due_beats.push_back(b);
    endfunction

    function pls_pkg::status_t insert_cell(int unsigned pos, logic signed [31:0] v);
      if (pos > held) return pls_pkg::ST_BADPOS;
      if (held >= CAPACITY) return pls_pkg::ST_FULL;
      for (int unsigned i = held; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = v;
      held++;
      return pls_pkg::ST_OK;
    endfunction

    function pls_pkg::status_t remove_cell(int unsigned pos);
      if (held == 0) return pls_pkg::ST_EMPTY;
      if (pos >= held) return pls_pkg::ST_BADPOS;
      for (int unsigned i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return pls_pkg::ST_OK;
    endfunction

    function void note_command(pls_pkg::in_beat_t c);
      pls_pkg::out_beat_t b;
      case (c.mode)
        pls_pkg::MODE_ADD_FRONT:  push_status(insert_cell(0, c.value));
        pls_pkg::MODE_ADD_BACK:   push_status(insert_cell(held, c.value));
        pls_pkg::MODE_ADD_AT:     push_status(insert_cell(32'(c.position), c.value));
        pls_pkg::MODE_DROP_FRONT: push_status(remove_cell(0));
        pls_pkg::MODE_DROP_BACK:
          push_status(held == 0 ? pls_pkg::ST_EMPTY : remove_cell(held - 1));
        pls_pkg::MODE_DROP_AT:    push_status(remove_cell(32'(c.position)));
        pls_pkg::MODE_DUMP: begin
          if (held == 0) begin
            push_status(pls_pkg::ST_EMPTY);
          end else begin
            for (int unsigned i = 0; i < held; i++) begin
              b.status       = pls_pkg::ST_OK;
              b.entry        = cells[i];
              b.entries_held = 5'(held);
              b.last         = (i + 1 == held);
              due_beats.push_back(b);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(pls_pkg::out_beat_t got);
      pls_pkg::out_beat_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected beat: status %0d entry %0d held %0d last %0b",
               got.status, got.entry, got.entries_held, got.last);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.entry !== want.entry) begin
        $error("entry: expected %0d, got %0d", want.entry, got.entry);
        mismatches++;
      end
      if (got.entries_held !== want.entries_held) begin
        $error("entries_held: expected %0d, got %0d", want.entries_held, got.entries_held);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pls_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pls_pkg::out_beat_t out_data;

  bit        quiet = 1'b0;
  list_mirror mirror = new();

  positional_list_store #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_beat(out_data);
  end

  // called at a rising edge; leaves valid high unless a gap is taken
  task automatic send(pls_pkg::in_beat_t c);
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    mirror.note_command(c);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(pls_pkg::mode_t m, logic signed [31:0] v, logic [7:0] p);
    pls_pkg::in_beat_t c;
    c.mode     = m;
    c.value    = v;
    c.position = p;
    send(c);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic pls_pkg::in_beat_t pick_command(bit filling);
    pls_pkg::in_beat_t c;
    int unsigned       r;
    int unsigned       n;
    n          = mirror.held;
    r          = $urandom_range(99);
    c.value    = pick_value();
    c.position = 8'($urandom_range(255));
    if (r < 5) begin
      c.mode = pls_pkg::MODE_DUMP;
    end else if (r < 7) begin
      c.mode = MODE_RESERVED;
    end else if ($urandom_range(99) < (filling ? 70 : 30)) begin
      case ($urandom_range(2))
        0:       c.mode = pls_pkg::MODE_ADD_FRONT;
        1:       c.mode = pls_pkg::MODE_ADD_BACK;
        default: c.mode = pls_pkg::MODE_ADD_AT;
      endcase
      if ($urandom_range(99) < 80) c.position = 8'($urandom_range(n, 0));
    end else begin
      case ($urandom_range(2))
        0:       c.mode = pls_pkg::MODE_DROP_FRONT;
        1:       c.mode = pls_pkg::MODE_DROP_BACK;
        default: c.mode = pls_pkg::MODE_DROP_AT;
      endcase
      if (n > 0 && $urandom_range(99) < 80) c.position = 8'($urandom_range(n - 1, 0));
    end
    return c;
  endfunction

  initial begin
    pls_pkg::in_beat_t c;
    int                sent;
    bit                filling;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every remove and the dump report empty; then directed adds, drops, bad positions, mode 7 and dumps
    send_cmd(pls_pkg::MODE_DUMP,       '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_FRONT, '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_BACK,  '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_AT,    '0, 8'd0);
    send_cmd(pls_pkg::MODE_ADD_AT,     32'sd7, 8'd1);
    send_cmd(pls_pkg::MODE_ADD_FRONT,  32'sh8000_0000, 8'd0);
    send_cmd(pls_pkg::MODE_ADD_BACK,   32'sh7fff_ffff, 8'd0);
    send_cmd(pls_pkg::MODE_ADD_AT,     32'sh5555_5555, 8'd1);
    send_cmd(pls_pkg::MODE_ADD_AT,     32'shaaaa_aaaa, 8'd3);
    send_cmd(pls_pkg::MODE_ADD_AT,     -32'sd1, 8'd5);
    send_cmd(pls_pkg::MODE_DUMP,       '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_AT,    '0, 8'd255);
    send_cmd(pls_pkg::MODE_ADD_AT,     32'sd0, 8'd255);
    send_cmd(pls_pkg::MODE_DROP_AT,    '0, 8'd4);
    send_cmd(MODE_RESERVED,            32'sd99, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_AT,    '0, 8'd1);
    send_cmd(pls_pkg::MODE_DROP_BACK,  '0, 8'd0);
    send_cmd(pls_pkg::MODE_DUMP,       '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_FRONT, '0, 8'd0);
    send_cmd(pls_pkg::MODE_DROP_FRONT, '0, 8'd0);
    send_cmd(pls_pkg::MODE_DUMP,       '0, 8'd0);

    // alternate fill-heavy and drain-heavy phases to hit full and empty often
    sent    = 0;
    filling = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 120 && sent < 180);
      c     = pick_command(filling);
      send(c);
      if (c.mode != MODE_RESERVED) begin
        sent++;
        if (sent % 40 == 0) filling = !filling;
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (mirror.due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
